>>> sv/lrt_pkg.sv
// lrt_pkg: shared types, register map and defaults for the LRU residency tracker.
// Used by lrt_cell and lru_residency_tracker_unit; no dependencies.
`default_nettype none

package lrt_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;

  localparam int CAP_W    = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int EVKEY_W  = 32;
  localparam int AKEY_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic EV_INSERT = 1'b0;
  localparam logic EV_EVICT  = 1'b1;

  typedef struct packed {
    logic apply;
    logic clear;
  } lrt_ctrl_t;

  typedef struct packed {
    logic               kind;
    logic [EVKEY_W-1:0] key;
    logic               last;
  } lrt_event_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } lrt_state_t;

endpackage

`default_nettype wire

>>> sv/lrt_cell.sv
// lrt_cell: one slot of the recency stack; holds a key and a valid bit,
// compares against the looked-up key and takes its neighbor's slot on a shift.
// Depends on lrt_pkg.
`default_nettype none

module lrt_cell
  import lrt_pkg::*;
#(
  parameter int INDEX    = 0,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int IDX_W    = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lrt_ctrl_t           ctrl,
  input  wire logic [IDX_W-1:0]    pos,
  input  wire logic [KEY_BITS-1:0] prev_key,
  input  wire logic                prev_valid,
  input  wire logic [KEY_BITS-1:0] look_key,
  output logic      [KEY_BITS-1:0] key,
  output logic                     valid,
  output logic                     match
);

  logic shift;

  assign shift = ctrl.apply && (IDX_W'(INDEX) <= pos);
  assign match = valid && (key == look_key);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key <= prev_key;
    end
  end

endmodule

`default_nettype wire

>>> sv/lru_residency_tracker_unit.sv
// lru_residency_tracker_unit: fully associative LRU tracker built as a row of lrt_cell slots,
// with an APB capacity register and a two-word result queue.
// Depends on lrt_pkg and lrt_cell.
//
//  channel   | dir | handshake              | payload
//  s_axis    | in  | tvalid/tready          | tdata[31:0] access_key
//  m_axis    | out | tvalid/tready          | tdata[31:0] event_key, tuser event_kind, tlast
//  apb       | in  | psel/penable/pready    | capacity at address 0
//
// An access passes through accept, parallel compare over all slots, then stack shift.
// The shift waits until the result queue has drained, so a stalled output holds the next
// access in the shift stage with its compare result kept. A hit or a miss with room gives
// one word, a full miss two. Reset and any capacity write clear all slots.
`default_nettype none

module lru_residency_tracker_unit
  import lrt_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [AKEY_W-1:0]  s_axis_tdata,   // [31:0] access_key
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [EVKEY_W-1:0] m_axis_tdata,   // [31:0] event_key
  output logic                    m_axis_tuser,   // [0] event_kind
  output logic                    m_axis_tlast,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  lrt_state_t state, state_next;

  logic [CAP_W-1:0]    capacity;
  logic [CNT_W-1:0]    resident_count;
  logic [CNT_W-1:0]    cap_eff;
  logic [CMP_W-1:0]    cap_ext;
  logic                cfg_wr;

  logic [KEY_BITS-1:0] key_r;
  logic                hit_r;
  logic                full_r;
  logic [IDX_W-1:0]    pos_r;
  logic [KEY_BITS-1:0] victim_r;

  logic [KEY_BITS-1:0]    cell_key [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_valid;
  logic [MAX_ENTRIES-1:0] cell_match;
  logic [MAX_ENTRIES-1:0] cell_last;

  logic                hit_c;
  logic                full_c;
  logic [IDX_W-1:0]    hit_pos_c;
  logic [KEY_BITS-1:0] victim_c;

  lrt_ctrl_t  ctrl;
  logic       go;
  lrt_event_t q0, q1;
  logic [1:0] qcnt;
  logic       pop;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_ext);
    end
  end

  // control
  assign s_axis_tready = (state == S_IDLE);
  assign go            = (state == S_UPD) && (qcnt == 2'd0);
  assign ctrl          = '{apply: go, clear: cfg_wr};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_LOOK;
      S_LOOK: state_next = S_UPD;
      S_UPD:  if (go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_r <= KEY_BITS'(s_axis_tdata);
    end
  end

  // cell row
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key;
    logic                prev_valid;

    if (i == 0) begin : g_head
      assign prev_key   = key_r;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign cell_last[i] = cell_valid[i];
    end else begin : g_mid
      assign cell_last[i] = cell_valid[i] && !cell_valid[i+1];
    end

    lrt_cell #(
      .INDEX    (i),
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .pos        (pos_r),
      .prev_key   (prev_key),
      .prev_valid (prev_valid),
      .look_key   (key_r),
      .key        (cell_key[i]),
      .valid      (cell_valid[i]),
      .match      (cell_match[i])
    );
  end

  // match encode and victim select
  always_comb begin
    hit_pos_c = '0;
    victim_c  = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (cell_match[j]) hit_pos_c = hit_pos_c | IDX_W'(j);
      if (cell_last[j])  victim_c  = victim_c | cell_key[j];
    end
  end

  assign hit_c  = |cell_match;
  assign full_c = !(resident_count < cap_eff);

  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      hit_r    <= hit_c;
      full_r   <= full_c;
      victim_r <= victim_c;
      if (hit_c) begin
        pos_r <= hit_pos_c;
      end else if (full_c) begin
        pos_r <= IDX_W'(resident_count - CNT_W'(1));
      end else begin
        pos_r <= IDX_W'(resident_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      resident_count <= '0;
    end else if (go && !hit_r && !full_r) begin
      resident_count <= resident_count + CNT_W'(1);
    end
  end

  // result queue
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (qcnt != 2'd0);
  assign m_axis_tdata  = q0.key;
  assign m_axis_tuser  = q0.kind;
  assign m_axis_tlast  = q0.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= 2'd0;
    end else if (go) begin
      qcnt <= (!hit_r && full_r) ? 2'd2 : 2'd1;
    end else if (pop) begin
      qcnt <= qcnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (!hit_r && full_r) begin
        q0 <= '{kind: EV_EVICT, key: EVKEY_W'(victim_r), last: 1'b0};
        q1 <= '{kind: EV_INSERT, key: EVKEY_W'(key_r), last: 1'b1};
      end else begin
        q0 <= '{kind: EV_INSERT, key: EVKEY_W'(key_r), last: 1'b1};
      end
    end else if (pop) begin
      q0 <= q1;
    end
  end

  // checks
  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("slot valid bits not packed at the front");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(resident_count))
    else $error("resident count disagrees with valid slots");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |-> $onehot0(cell_match))
    else $error("key resident in more than one slot");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    resident_count <= cap_eff)
    else $error("resident count above capacity");

  a_evict_pair: assert property (@(posedge clk) disable iff (rst || cfg_wr)
    go && !hit_r && full_r |=> qcnt == 2'd2 && m_axis_tuser == EV_EVICT)
    else $error("full miss did not queue an eviction first");

endmodule

`default_nettype wire
